>>> hw/rtl/nsv_pkg.sv
// ----------------------------------------------------------------------------
// nsv_pkg
// Shared types, character codes and decode helpers for the sentence validator.
// ----------------------------------------------------------------------------
package nsv_pkg;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [5:0] FIELD_MAX = 6'd63;
    localparam logic [2:0] ADDR_MAX  = 3'd7;
    localparam logic [2:0] ADDR_LEN  = 3'd5;

    // type letters packed first character high
    localparam logic [23:0] CODE_GGA = 24'h474741;
    localparam logic [23:0] CODE_RMC = 24'h524D43;
    localparam logic [23:0] CODE_VTG = 24'h565447;
    localparam logic [23:0] CODE_GSA = 24'h475341;
    localparam logic [23:0] CODE_GSV = 24'h475356;

    localparam logic [4:0] MIN_GGA = 5'd15;
    localparam logic [4:0] MIN_RMC = 5'd12;
    localparam logic [4:0] MIN_VTG = 5'd9;
    localparam logic [4:0] MIN_GSA = 5'd18;
    localparam logic [4:0] MIN_GSV = 5'd4;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FORMAT     = 3'd1,
        ST_MISMATCH   = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_FEW_FIELDS = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        TYPE_NONE = 3'd0,
        TYPE_GGA  = 3'd1,
        TYPE_RMC  = 3'd2,
        TYPE_VTG  = 3'd3,
        TYPE_GSA  = 3'd4,
        TYPE_GSV  = 3'd5
    } sentence_type_t;

    typedef struct packed {
        status_t        status;
        sentence_type_t sentence_type;
        logic [5:0]     field_count;
        logic [7:0]     computed_sum;
    } result_t;

    typedef struct packed {
        sentence_type_t sentence_type;
        logic [4:0]     min_fields;
    } type_info_t;

    function automatic type_info_t decode_type(input logic [23:0] letters);
        type_info_t info;
        info.sentence_type = TYPE_NONE;
        info.min_fields    = 5'd0;
        unique case (letters)
            CODE_GGA: begin info.sentence_type = TYPE_GGA; info.min_fields = MIN_GGA; end
            CODE_RMC: begin info.sentence_type = TYPE_RMC; info.min_fields = MIN_RMC; end
            CODE_VTG: begin info.sentence_type = TYPE_VTG; info.min_fields = MIN_VTG; end
            CODE_GSA: begin info.sentence_type = TYPE_GSA; info.min_fields = MIN_GSA; end
            CODE_GSV: begin info.sentence_type = TYPE_GSV; info.min_fields = MIN_GSV; end
            default:  begin info.sentence_type = TYPE_NONE; info.min_fields = 5'd0; end
        endcase
        return info;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            v = {1'b0, b[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/nsv_parser.sv
// ----------------------------------------------------------------------------
// nsv_parser
// Per-line state: checksum, field count, address decode and final status.
// ----------------------------------------------------------------------------
module nsv_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       char_in,
    output logic             result_valid,
    output nsv_pkg::result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_HEX  = 2'd2,
        PH_TAIL = 2'd3
    } phase_t;

    phase_t      phase_reg,          phase_next;
    logic        line_nonempty_reg,  line_nonempty_next;
    logic        start_ok_reg,       start_ok_next;
    logic [7:0]  running_xor_reg,    running_xor_next;
    logic [7:0]  received_sum_reg,   received_sum_next;
    logic [1:0]  hex_digits_reg,     hex_digits_next;
    logic        hex_bad_reg,        hex_bad_next;
    logic [5:0]  fields_seen_reg,    fields_seen_next;
    logic [2:0]  address_length_reg, address_length_next;
    logic [23:0] type_letters_reg,   type_letters_next;

    logic                 is_eol;
    logic [4:0]           hex_v;
    nsv_pkg::type_info_t  info;

    assign is_eol = (char_in == nsv_pkg::CH_CR) || (char_in == nsv_pkg::CH_LF);
    assign hex_v  = nsv_pkg::hex_value(char_in);

    // type only counts when the address field is exactly five characters
    always_comb
    begin
        info = nsv_pkg::decode_type(type_letters_reg);
        if (address_length_reg != nsv_pkg::ADDR_LEN) begin
            info.sentence_type = nsv_pkg::TYPE_NONE;
            info.min_fields    = 5'd0;
        end
    end

    always_comb
    begin
        result.sentence_type = info.sentence_type;
        result.field_count   = fields_seen_reg;
        result.computed_sum  = running_xor_reg;
        priority if (!start_ok_reg || phase_reg != PH_TAIL || hex_digits_reg != 2'd2
                     || hex_bad_reg) begin
            result.status = nsv_pkg::ST_FORMAT;
        end else if (running_xor_reg != received_sum_reg) begin
            result.status = nsv_pkg::ST_MISMATCH;
        end else if (info.sentence_type == nsv_pkg::TYPE_NONE) begin
            result.status = nsv_pkg::ST_UNKNOWN;
        end else if (fields_seen_reg < {1'b0, info.min_fields}) begin
            result.status = nsv_pkg::ST_FEW_FIELDS;
        end else begin
            result.status = nsv_pkg::ST_OK;
        end
    end

    assign result_valid = step && is_eol && line_nonempty_reg;

    always_comb
    begin
        phase_next          = phase_reg;
        line_nonempty_next  = line_nonempty_reg;
        start_ok_next       = start_ok_reg;
        running_xor_next    = running_xor_reg;
        received_sum_next   = received_sum_reg;
        hex_digits_next     = hex_digits_reg;
        hex_bad_next        = hex_bad_reg;
        fields_seen_next    = fields_seen_reg;
        address_length_next = address_length_reg;
        type_letters_next   = type_letters_reg;
        if (step) begin
            if (is_eol) begin
                // every line end clears the line state, empty or not
                phase_next          = PH_IDLE;
                line_nonempty_next  = 1'b0;
                start_ok_next       = 1'b0;
                running_xor_next    = 8'd0;
                received_sum_next   = 8'd0;
                hex_digits_next     = 2'd0;
                hex_bad_next        = 1'b0;
                fields_seen_next    = 6'd0;
                address_length_next = 3'd0;
                type_letters_next   = 24'd0;
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        line_nonempty_next = 1'b1;
                        start_ok_next      = (char_in == nsv_pkg::CH_DOLLAR);
                        fields_seen_next   = 6'd1;
                        phase_next         = PH_BODY;
                    end
                    PH_BODY: begin
                        if (char_in == nsv_pkg::CH_STAR) begin
                            phase_next = PH_HEX;
                        end else begin
                            running_xor_next = running_xor_reg ^ char_in;
                            if (char_in == nsv_pkg::CH_COMMA) begin
                                if (fields_seen_reg < nsv_pkg::FIELD_MAX) begin
                                    fields_seen_next = fields_seen_reg + 6'd1;
                                end
                            end else if (fields_seen_reg == 6'd1) begin
                                if (address_length_reg < nsv_pkg::ADDR_MAX) begin
                                    address_length_next = address_length_reg + 3'd1;
                                end
                                type_letters_next = {type_letters_reg[15:0], char_in};
                            end
                        end
                    end
                    PH_HEX: begin
                        if (hex_v[4]) begin
                            hex_bad_next = 1'b1;
                            phase_next   = PH_TAIL;
                        end else begin
                            received_sum_next = {received_sum_reg[3:0], hex_v[3:0]};
                            hex_digits_next   = hex_digits_reg + 2'd1;
                            if (hex_digits_reg == 2'd1) begin
                                phase_next = PH_TAIL;
                            end
                        end
                    end
                    PH_TAIL: begin
                        phase_next = PH_TAIL;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg          <= PH_IDLE;
            line_nonempty_reg  <= 1'b0;
            start_ok_reg       <= 1'b0;
            running_xor_reg    <= 8'd0;
            received_sum_reg   <= 8'd0;
            hex_digits_reg     <= 2'd0;
            hex_bad_reg        <= 1'b0;
            fields_seen_reg    <= 6'd0;
            address_length_reg <= 3'd0;
            type_letters_reg   <= 24'd0;
        end else begin
            phase_reg          <= phase_next;
            line_nonempty_reg  <= line_nonempty_next;
            start_ok_reg       <= start_ok_next;
            running_xor_reg    <= running_xor_next;
            received_sum_reg   <= received_sum_next;
            hex_digits_reg     <= hex_digits_next;
            hex_bad_reg        <= hex_bad_next;
            fields_seen_reg    <= fields_seen_next;
            address_length_reg <= address_length_next;
            type_letters_reg   <= type_letters_next;
        end
    end

endmodule

>>> hw/rtl/nsv_out_buffer.sv
// ----------------------------------------------------------------------------
// nsv_out_buffer
// Two-entry result register with skid slot, separates parser from receiver.
// ----------------------------------------------------------------------------
module nsv_out_buffer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nsv_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output nsv_pkg::result_t head
);

    logic [1:0]       count_reg, count_next;
    nsv_pkg::result_t slot0_reg;
    nsv_pkg::result_t slot1_reg;
    logic             pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head      = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // push never arrives while full
    always_ff @(posedge clk)
    begin
        if (pop) begin
            if (push && count_reg == 2'd1) begin
                slot0_reg <= push_data;
            end else begin
                slot0_reg <= slot1_reg;
                if (push) begin
                    slot1_reg <= push_data;
                end
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                slot0_reg <= push_data;
            end else begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

>>> hw/rtl/nmea_sentence_validator_core.sv
// ----------------------------------------------------------------------------
// nmea_sentence_validator_core
// Line checker: leading dollar, checksum, field count and sentence type.
// ----------------------------------------------------------------------------
// path: a line end waits in the byte register, then its result is buffered
// throughput: one byte per cycle when not stalled, set by the line state update
// stall rises only when both result slots are occupied
// reset: asynchronous active low, line state idle, both result slots empty
// ----------------------------------------------------------------------------
module nmea_sentence_validator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [2:0] sentence_type,
    output logic [5:0] field_count,
    output logic [7:0] computed_sum
);

    logic             byte_valid_reg;
    logic [7:0]       byte_reg;
    logic             in_accept;
    logic             advance;
    logic             buf_full;
    logic             result_valid;
    nsv_pkg::result_t result;
    nsv_pkg::result_t head;

    assign in_stall  = byte_valid_reg && buf_full;
    assign in_accept = in_valid && !in_stall;
    assign advance   = byte_valid_reg && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    nsv_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .char_in      (byte_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    nsv_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign status        = head.status;
    assign sentence_type = head.sentence_type;
    assign field_count   = head.field_count;
    assign computed_sum  = head.computed_sum;

    // input only backs up behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // a finished line always has at least its address field
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> field_count != 6'd0)
        else $error("result with zero field count");

    // accepted or short lines carry a known type, unknown lines carry none
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == nsv_pkg::ST_OK || status == nsv_pkg::ST_FEW_FIELDS)
        |-> sentence_type != nsv_pkg::TYPE_NONE)
        else $error("accepted line without sentence type");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == nsv_pkg::ST_UNKNOWN |-> sentence_type == nsv_pkg::TYPE_NONE)
        else $error("unknown type status with decoded type");

endmodule

>>> tb/nsv_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_line_checker
// Watches both channels of the sentence validator, rebuilds each line's
// status report from the accepted bytes and compares it with the block.
// ----------------------------------------------------------------------------
module nsv_line_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [2:0]  sentence_type,
    input  logic [5:0]  field_count,
    input  logic [7:0]  computed_sum,
    output int unsigned fail_count,
    output int unsigned lines_pending
);

    typedef enum logic [1:0] {
        LN_IDLE = 2'd0,
        LN_BODY = 2'd1,
        LN_HEX  = 2'd2,
        LN_TAIL = 2'd3
    } line_phase_t;

    line_phase_t phase_q;
    logic        in_line;
    logic        dollar_first;
    logic [7:0]  sum_acc;
    logic [7:0]  sum_given;
    logic [1:0]  digits_got;
    logic        digit_err;
    logic [5:0]  field_tally;
    logic [2:0]  addr_len;
    logic [23:0] addr_tail;

    nsv_pkg::result_t expected_reports[$];
    nsv_pkg::result_t head;
    int unsigned      fails = 0;

    function automatic nsv_pkg::sentence_type_t type_of(input logic [23:0] letters);
        case (letters)
            nsv_pkg::CODE_GGA: return nsv_pkg::TYPE_GGA;
            nsv_pkg::CODE_RMC: return nsv_pkg::TYPE_RMC;
            nsv_pkg::CODE_VTG: return nsv_pkg::TYPE_VTG;
            nsv_pkg::CODE_GSA: return nsv_pkg::TYPE_GSA;
            nsv_pkg::CODE_GSV: return nsv_pkg::TYPE_GSV;
            default:           return nsv_pkg::TYPE_NONE;
        endcase
    endfunction

    function automatic int min_fields_of(input nsv_pkg::sentence_type_t kind);
        case (kind)
            nsv_pkg::TYPE_GGA: return int'(nsv_pkg::MIN_GGA);
            nsv_pkg::TYPE_RMC: return int'(nsv_pkg::MIN_RMC);
            nsv_pkg::TYPE_VTG: return int'(nsv_pkg::MIN_VTG);
            nsv_pkg::TYPE_GSA: return int'(nsv_pkg::MIN_GSA);
            nsv_pkg::TYPE_GSV: return int'(nsv_pkg::MIN_GSV);
            default:           return 0;
        endcase
    endfunction

    // bit 4 flags a character that is not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 5'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46)
            return 5'(c - 8'h37);
        if (c >= 8'h61 && c <= 8'h66)
            return 5'(c - 8'h57);
        return 5'h10;
    endfunction

    task automatic clear_line();
        phase_q      = LN_IDLE;
        in_line      = 1'b0;
        dollar_first = 1'b0;
        sum_acc      = 8'h00;
        sum_given    = 8'h00;
        digits_got   = 2'd0;
        digit_err    = 1'b0;
        field_tally  = 6'd0;
        addr_len     = 3'd0;
        addr_tail    = 24'h0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        nsv_pkg::result_t        rep;
        nsv_pkg::sentence_type_t kind;
        int                      need;
        logic [4:0]              nib;
        if (c == nsv_pkg::CH_CR || c == nsv_pkg::CH_LF)
        begin
            if (in_line)
            begin
                kind = nsv_pkg::TYPE_NONE;
                need = 0;
                if (addr_len == nsv_pkg::ADDR_LEN)
                begin
                    kind = type_of(addr_tail);
                    need = min_fields_of(kind);
                end
                if (!dollar_first || phase_q != LN_TAIL || digits_got != 2'd2 || digit_err)
                    rep.status = nsv_pkg::ST_FORMAT;
                else if (sum_acc != sum_given)
                    rep.status = nsv_pkg::ST_MISMATCH;
                else if (kind == nsv_pkg::TYPE_NONE)
                    rep.status = nsv_pkg::ST_UNKNOWN;
                else if (int'(field_tally) < need)
                    rep.status = nsv_pkg::ST_FEW_FIELDS;
                else
                    rep.status = nsv_pkg::ST_OK;
                rep.sentence_type = kind;
                rep.field_count   = field_tally;
                rep.computed_sum  = sum_acc;
                expected_reports = {expected_reports, rep};
            end
            clear_line();
        end
        else
        begin
            case (phase_q)
                LN_IDLE:
                begin
                    // first character is never summed, even when it is not a dollar
                    in_line      = 1'b1;
                    dollar_first = (c == nsv_pkg::CH_DOLLAR);
                    field_tally  = 6'd1;
                    phase_q      = LN_BODY;
                end
                LN_BODY:
                begin
                    if (c == nsv_pkg::CH_STAR)
                        phase_q = LN_HEX;
                    else
                    begin
                        sum_acc = sum_acc ^ c;
                        if (c == nsv_pkg::CH_COMMA)
                        begin
                            if (field_tally != nsv_pkg::FIELD_MAX)
                                field_tally = field_tally + 6'd1;
                        end
                        else if (field_tally == 6'd1)
                        begin
                            if (addr_len != nsv_pkg::ADDR_MAX)
                                addr_len = addr_len + 3'd1;
                            addr_tail = {addr_tail[15:0], c};
                        end
                    end
                end
                LN_HEX:
                begin
                    nib = nibble_of(c);
                    if (nib[4])
                    begin
                        digit_err = 1'b1;
                        phase_q   = LN_TAIL;
                    end
                    else
                    begin
                        sum_given  = {sum_given[3:0], nib[3:0]};
                        digits_got = digits_got + 2'd1;
                        if (digits_got == 2'd2)
                            phase_q = LN_TAIL;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            expected_reports.delete();
            lines_pending <= 0;
            fail_count    <= fails;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("status report with no line pending: status %0d, field_count %0d",
                           status, field_count);
                    fails++;
                end
                else
                begin
                    head = expected_reports.pop_front();
                    compare_field("status", 8'(head.status), 8'(status));
                    compare_field("sentence_type", 8'(head.sentence_type), 8'(sentence_type));
                    compare_field("field_count", 8'(head.field_count), 8'(field_count));
                    compare_field("computed_sum", head.computed_sum, computed_sum);
                end
            end
            if (in_valid && !in_stall)
                absorb_char(rx_byte);
            lines_pending <= expected_reports.size();
            fail_count    <= fails;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds the sentence validator directed and random NMEA lines, noise and
// malformed sentences under bursty input and random output stalls; the
// line checker predicts every status report.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_BYTES    = 150;

    typedef enum int {
        FL_NONE        = 0,
        FL_BAD_SUM     = 1,
        FL_NO_DOLLAR   = 2,
        FL_NO_STAR     = 3,
        FL_SHORT_HEX   = 4,
        FL_BAD_HEX     = 5,
        FL_DOUBLE_STAR = 6,
        FL_TRAILING    = 7,
        FL_ADDR_SHORT  = 8,
        FL_ADDR_LONG   = 9
    } flaw_t;
    localparam int FLAW_COUNT = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [2:0]  sentence_type;
    logic [5:0]  field_count;
    logic [7:0]  computed_sum;
    int unsigned fail_count;
    int unsigned lines_pending;

    logic [7:0]  line_buf[$];
    logic [7:0]  body_sum;
    int unsigned burst_left;
    int unsigned bytes_sent;
    int unsigned lines_sent;
    int unsigned reports_seen  = 0;
    int unsigned idle_cycles   = 0;
    bit          hold_off_req  = 1'b0;
    bit          hold_off_done = 1'b0;

    logic [23:0] known_codes[5] = '{nsv_pkg::CODE_GGA, nsv_pkg::CODE_RMC,
                                    nsv_pkg::CODE_VTG, nsv_pkg::CODE_GSA,
                                    nsv_pkg::CODE_GSV};
    int          known_mins[5]  = '{nsv_pkg::MIN_GGA, nsv_pkg::MIN_RMC,
                                    nsv_pkg::MIN_VTG, nsv_pkg::MIN_GSA,
                                    nsv_pkg::MIN_GSV};

    nmea_sentence_validator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .sentence_type (sentence_type),
        .field_count   (field_count),
        .computed_sum  (computed_sum)
    );

    nsv_line_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .sentence_type (sentence_type),
        .field_count   (field_count),
        .computed_sum  (computed_sum),
        .fail_count    (fail_count),
        .lines_pending (lines_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // any byte except line ends, asterisk and comma; mostly printable
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0, 1:    c = 8'h30 + 8'($urandom_range(0, 9));
            2:       c = 8'h2E;
            3:       c = 8'h41 + 8'($urandom_range(0, 25));
            default:
            begin
                c = 8'($urandom_range(0, 255));
                while (c == nsv_pkg::CH_CR || c == nsv_pkg::CH_LF
                       || c == nsv_pkg::CH_STAR || c == nsv_pkg::CH_COMMA)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
    endfunction

    function automatic logic [7:0] not_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == nsv_pkg::CH_CR || c == nsv_pkg::CH_LF || (c >= 8'h30 && c <= 8'h39)
               || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic append_byte(input logic [7:0] c);
        line_buf = {line_buf, c};
    endtask

    task automatic put_body(input logic [7:0] c);
        append_byte(c);
        body_sum = body_sum ^ c;
    endtask

    // CRLF, lone CR, lone LF, or a doubled LF that leaves an empty line
    task automatic put_line_end();
        case ($urandom_range(0, 3))
            0:
            begin
                append_byte(nsv_pkg::CH_CR);
                append_byte(nsv_pkg::CH_LF);
            end
            1:       append_byte(nsv_pkg::CH_CR);
            2:       append_byte(nsv_pkg::CH_LF);
            default:
            begin
                append_byte(nsv_pkg::CH_LF);
                append_byte(nsv_pkg::CH_LF);
            end
        endcase
    endtask

    task automatic build_sentence(input logic [23:0] letters, input int n_fields,
                                  input flaw_t flaw, input int field_len);
        logic [7:0] c;
        int         k;
        line_buf.delete();
        body_sum = 8'h00;
        if (flaw == FL_NO_DOLLAR)
        begin
            c = field_char();
            while (c == nsv_pkg::CH_DOLLAR)
                c = field_char();
            append_byte(c);
        end
        else
            append_byte(nsv_pkg::CH_DOLLAR);
        // talker: usually GP or GN, sometimes arbitrary bytes
        if ($urandom_range(0, 3) != 0)
        begin
            put_body(8'h47);
            put_body(($urandom_range(0, 1) != 0) ? 8'h50 : 8'h4E);
        end
        else
        begin
            put_body(field_char());
            put_body(field_char());
        end
        put_body(letters[23:16]);
        put_body(letters[15:8]);
        if (flaw != FL_ADDR_SHORT)
            put_body(letters[7:0]);
        if (flaw == FL_ADDR_LONG)
            put_body(field_char());
        for (k = 1; k < n_fields; k++)
        begin
            put_body(nsv_pkg::CH_COMMA);
            repeat ($urandom_range(0, field_len))
                put_body(field_char());
        end
        if (flaw != FL_NO_STAR)
        begin
            append_byte(nsv_pkg::CH_STAR);
            if (flaw == FL_BAD_SUM)
                body_sum = body_sum ^ 8'($urandom_range(1, 255));
            if (flaw == FL_DOUBLE_STAR)
                append_byte(nsv_pkg::CH_STAR);
            append_byte(hex_char(body_sum[7:4]));
            if (flaw != FL_SHORT_HEX)
                append_byte(hex_char(body_sum[3:0]));
            if (flaw == FL_BAD_HEX)
                line_buf[line_buf.size() - 1 - $urandom_range(0, 1)] = not_hex_char();
            if (flaw == FL_TRAILING)
                repeat ($urandom_range(1, 4))
                    append_byte(($urandom_range(0, 3) == 0) ? nsv_pkg::CH_STAR : field_char());
        end
        put_line_end();
    endtask

    task automatic build_noise(input int len);
        line_buf.delete();
        if ($urandom_range(0, 1) != 0)
            append_byte(nsv_pkg::CH_DOLLAR);
        repeat (len)
            append_byte(8'($urandom_range(0, 255)));
        put_line_end();
    endtask

    // bursts of random length with random gaps, valid held through stalls
    task automatic send_item(input logic [7:0] c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        int k;
        for (k = 0; k < line_buf.size(); k++)
            send_item(line_buf[k]);
        lines_sent++;
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (lines_pending != 0)
            @(posedge clk);
    endtask

    // receiver stall pattern, plus one long hold-off on request
    initial
    begin
        int unsigned stretch;
        int unsigned pct;
        out_stall = 1'b0;
        forever
        begin
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 25;
                2:       pct = 50;
                default: pct = 90;
            endcase
            stretch = $urandom_range(4, 60);
            while (stretch != 0 && !(hold_off_req && !hold_off_done))
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 99) < pct);
                stretch--;
            end
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
        end
    end

    // report counter and watchdog
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            reports_seen <= reports_seen + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          k;
        int          n;
        int          pick;
        int          rounds;
        int unsigned random_start;
        logic [23:0] letters;
        flaw_t       flaw;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        burst_left = 0;
        bytes_sent = 0;
        lines_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every sentence type at exactly its minimum field count
        for (k = 0; k < 5; k++)
        begin
            build_sentence(known_codes[k], known_mins[k], FL_NONE, 1);
            send_line();
        end
        // each way a line can be malformed
        for (k = 1; k < FLAW_COUNT; k++)
        begin
            build_sentence(known_codes[k % 5], known_mins[k % 5], flaw_t'(k), 1);
            send_line();
        end
        build_sentence(24'h58595A, 6, FL_NONE, 1);
        send_line();
        build_sentence(nsv_pkg::CODE_GSV, known_mins[4] - 1, FL_NONE, 1);
        send_line();
        build_sentence(nsv_pkg::CODE_GSA, known_mins[3] - 1, FL_NONE, 1);
        send_line();
        // field count saturates
        build_sentence(nsv_pkg::CODE_GGA, 70, FL_NONE, 0);
        send_line();
        // empty lines, a bare dollar, and the byte extremes
        line_buf = '{nsv_pkg::CH_LF};
        send_line();
        line_buf = '{nsv_pkg::CH_CR, nsv_pkg::CH_LF};
        send_line();
        line_buf = '{nsv_pkg::CH_DOLLAR, nsv_pkg::CH_CR};
        send_line();
        line_buf = '{8'h00, 8'hFF, nsv_pkg::CH_LF};
        send_line();

        // random part: mostly well-formed sentences, some near misses and noise
        hold_off_req = 1'b1;
        random_start = bytes_sent;
        rounds       = 0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                k    = $urandom_range(0, 4);
                n    = known_mins[k] + int'($urandom_range(0, 5)) - 2;
                flaw = ($urandom_range(0, 2) == 0) ? flaw_t'($urandom_range(1, FLAW_COUNT - 1))
                                                   : FL_NONE;
                build_sentence(known_codes[k], n, flaw, 2);
            end
            else if (pick < 85)
            begin
                // one flipped bit in a known code, or three arbitrary field characters
                if ($urandom_range(0, 1) != 0)
                    letters = known_codes[$urandom_range(0, 4)] ^ (24'h1 << $urandom_range(0, 23));
                else
                    letters = {field_char(), field_char(), field_char()};
                build_sentence(letters, $urandom_range(1, 8), FL_NONE, 2);
            end
            else
                build_noise($urandom_range(1, 16));
            send_line();
            rounds++;
            if (rounds == 3)
                drain_reports();
        end

        drain_reports();
        repeat (8) @(posedge clk);
        $display("tb: %0d bytes in %0d lines sent, %0d status reports compared",
                 bytes_sent, lines_sent, reports_seen);
        $display("tb: covered all types and flaws, a %0d-cycle output hold-off and a mid-run drain",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && lines_pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
